// ----- sv/sorted_table_insert_find_delete_core_macros.svh -----
// Assertion macros used by the sorted table RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SORTED_TABLE_INSERT_FIND_DELETE_CORE_MACROS_SVH
`define SORTED_TABLE_INSERT_FIND_DELETE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define STFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted table check failed");

// Next-cycle implication, disabled while reset is low.
`define STFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted table check failed");

`endif

// ----- sv/stfd_pkg.sv -----
// Shared types and constants of the sorted table core.
// No dependencies; used by stfd_ram, stfd_ctrl and the top level.
`default_nettype none

package stfd_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [DATA_W-1:0] t_word;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_PROBE,
        S_SHIFT_UP,
        S_PLACE,
        S_SHIFT_DN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_word            wr_data;
    } t_ram_req;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] position;
        logic [CNT_W-1:0] fill_count;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/sorted_table_insert_find_delete_core.sv -----
// Sorted table top level: handshake ports, output register, RAM and sequencer.
// Depends on stfd_pkg, stfd_ram and stfd_ctrl.
//
// Keeps up to 32 signed 32-bit values in ascending order in a single-port-write,
// registered-read RAM. Each input item carries func (0 insert, 1 find, 2 delete)
// and value; each produces exactly one result item with status (0 done, 1 not
// found, 2 full), position and the fill_count after the operation. Insert goes
// after any equal values; find and delete act on the lowest equal entry. Codes
// other than the three operations report not found and change nothing.
// Timing: one item is in flight at a time. A binary search reads each probe
// entry in S_SEARCH and compares it in S_PROBE. Insert then moves one entry per
// cycle through the RAM read and write ports and writes the value in S_PLACE;
// delete moves count - position - 1 entries. Find ends after the search.
// Full inserts and unknown codes skip the search and go straight to the result.
// The result sits in an output register, so the next item may be accepted
// while the previous result still waits for o_out_valid/i_out_ready.
`default_nettype none

module sorted_table_insert_find_delete_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_func,
    input  wire logic signed [31:0]          i_value,
    // output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [1:0]                       o_status,
    output logic [stfd_pkg::IDX_W-1:0]       o_position,
    output logic [stfd_pkg::CNT_W-1:0]       o_fill_count
);

    stfd_pkg::t_ram_req w_ram_req;
    stfd_pkg::t_word    w_rd_data;
    stfd_pkg::t_result  w_result;
    logic               w_res_valid;
    logic               w_res_taken;

    logic               r_out_valid;
    stfd_pkg::t_result  r_out;

    stfd_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (w_ram_req),
        .o_rd_data (w_rd_data)
    );

    stfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_ram_req   (w_ram_req),
        .i_rd_data   (w_rd_data),
        .o_res_valid (w_res_valid),
        .i_res_taken (w_res_taken),
        .o_result    (w_result)
    );

    // Advance a finished result into the output register when it is empty
    // or being drained this cycle; otherwise hold it in the sequencer.
    assign w_res_taken = w_res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_taken) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_taken) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_position   = r_out.position;
    assign o_fill_count = r_out.fill_count;

endmodule

`default_nettype wire

// ----- sv/stfd_ram.sv -----
// Entry storage of the sorted table: one write port, one registered read port.
// Depends on stfd_pkg.
`default_nettype none

module stfd_ram (
    input  wire logic              i_clk,
    input  wire stfd_pkg::t_ram_req i_req,
    output stfd_pkg::t_word        o_rd_data
);

    stfd_pkg::t_word r_mem [stfd_pkg::CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        o_rd_data <= r_mem[i_req.rd_addr];
    end

endmodule

`default_nettype wire

// ----- sv/stfd_ctrl.sv -----
// Sequencer of the sorted table: binary search, entry shifting, result hold.
// Depends on stfd_pkg and the assertion macros header.
`default_nettype none
`include "sorted_table_insert_find_delete_core_macros.svh"

module stfd_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_func,
    input  wire stfd_pkg::t_word               i_value,
    output stfd_pkg::t_ram_req                 o_ram_req,
    input  wire stfd_pkg::t_word               i_rd_data,
    output logic                               o_res_valid,
    input  wire logic                          i_res_taken,
    output stfd_pkg::t_result                  o_result
);

    localparam int CNT_W = stfd_pkg::CNT_W;
    localparam int IDX_W = stfd_pkg::IDX_W;

    stfd_pkg::t_state   r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_pend,  n_pend;
    logic [1:0]         r_func,  n_func;
    stfd_pkg::t_word    r_value, n_value;
    logic [CNT_W-1:0]   r_lo,    n_lo;
    logic [CNT_W-1:0]   r_hi,    n_hi;
    logic [CNT_W-1:0]   r_mid,   n_mid;
    logic               r_hit,   n_hit;
    logic [CNT_W-1:0]   r_ptr,   n_ptr;
    logic [IDX_W-1:0]   r_waddr, n_waddr;
    stfd_pkg::t_status  r_status, n_status;
    logic [IDX_W-1:0]   r_pos,   n_pos;

    logic [CNT_W:0]     w_sum;
    logic [CNT_W-1:0]   w_mid;
    logic [CNT_W-1:0]   w_ptr_dec;
    logic [CNT_W-1:0]   w_ptr_inc;
    logic               w_go_right;

    assign w_sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_sum[CNT_W:1];
    assign w_ptr_dec = r_ptr - 1'b1;
    assign w_ptr_inc = r_ptr + 1'b1;
    // Insert lands after equal values, find and delete stop at the first one.
    assign w_go_right = (r_func == stfd_pkg::OP_INSERT) ? (i_rd_data <= r_value)
                                                        : (i_rd_data <  r_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stfd_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_value  <= n_value;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_hit    <= n_hit;
        r_ptr    <= n_ptr;
        r_waddr  <= n_waddr;
        r_status <= n_status;
        r_pos    <= n_pos;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pend   = r_pend;
        n_func   = r_func;
        n_value  = r_value;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_hit    = r_hit;
        n_ptr    = r_ptr;
        n_waddr  = r_waddr;
        n_status = r_status;
        n_pos    = r_pos;

        o_ram_req.rd_addr = w_mid[IDX_W-1:0];
        o_ram_req.wr_en   = 1'b0;
        o_ram_req.wr_addr = r_waddr;
        o_ram_req.wr_data = i_rd_data;

        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            stfd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_func   = i_func;
                    n_value  = i_value;
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_hit    = 1'b0;
                    n_pend   = 1'b0;
                    n_status = stfd_pkg::ST_MISSING;
                    n_pos    = '0;
                    n_state  = stfd_pkg::S_SEARCH;
                    if (i_func == stfd_pkg::OP_INSERT &&
                        r_count >= CNT_W'(stfd_pkg::CAPACITY)) begin
                        n_status = stfd_pkg::ST_FULL;
                        n_state  = stfd_pkg::S_DONE;
                    end else if (i_func != stfd_pkg::OP_INSERT &&
                                 i_func != stfd_pkg::OP_FIND &&
                                 i_func != stfd_pkg::OP_DELETE) begin
                        n_state  = stfd_pkg::S_DONE;
                    end
                end
            end

            stfd_pkg::S_SEARCH: begin
                if (r_lo < r_hi) begin
                    n_mid   = w_mid;
                    n_state = stfd_pkg::S_PROBE;
                end else begin
                    case (r_func)
                        stfd_pkg::OP_INSERT: begin
                            n_ptr   = r_count;
                            n_state = stfd_pkg::S_SHIFT_UP;
                        end
                        stfd_pkg::OP_DELETE: begin
                            if (r_hit) begin
                                n_ptr   = r_lo + 1'b1;
                                n_state = stfd_pkg::S_SHIFT_DN;
                            end else begin
                                n_state = stfd_pkg::S_DONE;
                            end
                        end
                        default: begin
                            if (r_hit) begin
                                n_status = stfd_pkg::ST_DONE;
                                n_pos    = r_lo[IDX_W-1:0];
                            end
                            n_state = stfd_pkg::S_DONE;
                        end
                    endcase
                end
            end

            stfd_pkg::S_PROBE: begin
                // Read data for r_mid arrived this cycle.
                if (w_go_right) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi  = r_mid;
                    n_hit = (i_rd_data == r_value);
                end
                n_state = stfd_pkg::S_SEARCH;
            end

            stfd_pkg::S_SHIFT_UP: begin
                o_ram_req.wr_en = r_pend;
                if (r_ptr > r_lo) begin
                    o_ram_req.rd_addr = w_ptr_dec[IDX_W-1:0];
                    n_waddr = r_ptr[IDX_W-1:0];
                    n_pend  = 1'b1;
                    n_ptr   = w_ptr_dec;
                end else begin
                    n_pend  = 1'b0;
                    n_state = stfd_pkg::S_PLACE;
                end
            end

            stfd_pkg::S_PLACE: begin
                o_ram_req.wr_en   = 1'b1;
                o_ram_req.wr_addr = r_lo[IDX_W-1:0];
                o_ram_req.wr_data = r_value;
                n_count  = r_count + 1'b1;
                n_status = stfd_pkg::ST_DONE;
                n_pos    = r_lo[IDX_W-1:0];
                n_state  = stfd_pkg::S_DONE;
            end

            stfd_pkg::S_SHIFT_DN: begin
                o_ram_req.wr_en = r_pend;
                if (r_ptr < r_count) begin
                    o_ram_req.rd_addr = r_ptr[IDX_W-1:0];
                    n_waddr = w_ptr_dec[IDX_W-1:0];
                    n_pend  = 1'b1;
                    n_ptr   = w_ptr_inc;
                end else begin
                    n_pend   = 1'b0;
                    n_count  = r_count - 1'b1;
                    n_status = stfd_pkg::ST_DONE;
                    n_pos    = r_lo[IDX_W-1:0];
                    n_state  = stfd_pkg::S_DONE;
                end
            end

            stfd_pkg::S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_taken) begin
                    n_state = stfd_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = stfd_pkg::S_IDLE;
            end
        endcase
    end

    assign o_result.status     = r_status;
    assign o_result.position   = r_pos;
    assign o_result.fill_count = r_count;

    `STFD_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(stfd_pkg::CAPACITY))
    `STFD_ASSERT_NOW(a_write_in_update, i_clk, i_rst_n, o_ram_req.wr_en, r_state == stfd_pkg::S_SHIFT_UP || r_state == stfd_pkg::S_SHIFT_DN || r_state == stfd_pkg::S_PLACE)
    `STFD_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, r_state == stfd_pkg::S_IDLE && i_in_valid, r_state != stfd_pkg::S_IDLE)
    `STFD_ASSERT_NEXT(a_place_counts_up, i_clk, i_rst_n, r_state == stfd_pkg::S_PLACE, r_count == $past(r_count) + 1'b1)

endmodule

`default_nettype wire
